// ===== rtl/calendar_date_converter_unit_macros.svh =====
// Assertion macros for the calendar date converter.
// Expects i_clk and i_rst_n in scope of the including module.
`ifndef CALENDAR_DATE_CONVERTER_UNIT_MACROS_SVH
`define CALENDAR_DATE_CONVERTER_UNIT_MACROS_SVH

`define CDCU_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define CDCU_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cdcu_pkg.sv =====
// Types, constants and lookup functions for the calendar date converter.
// No dependencies.
package cdcu_pkg;

    localparam int YEAR_W  = 21;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int LATENCY = 11;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_G2J = 2'd0;
    localparam t_kind KIND_J2G = 2'd1;
    localparam t_kind KIND_G2R = 2'd2;
    localparam t_kind KIND_R2G = 2'd3;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MIN_YEAR = 1'b0;
    localparam t_cfg_idx CFG_MAX_YEAR = 1'b1;

    typedef logic signed [YEAR_W-1:0] t_year;
    localparam t_year MIN_YEAR_RST = -21'sd5508;
    localparam t_year MAX_YEAR_RST = 21'sd999999;

    typedef struct packed {
        t_kind kind;
        logic  err;
    } t_ctl;

    // floor(y/4)/25 by reciprocal
    localparam int Q25_SH   = 25;
    localparam int Q25_BIAS = 10486;
    localparam logic [19:0] Q25_OFS = 20'd262150;
    localparam logic [20:0] Q25_MUL = 21'(((64'd1 << Q25_SH) + 64'd24) / 64'd25);

    // (y+300)/900 and (y+700)/900
    localparam int Q900_SH   = 32;
    localparam int Q900_BIAS = 1166;
    localparam logic [21:0] Q900_OFS_A = 22'd1049700;
    localparam logic [21:0] Q900_OFS_B = 22'd1050100;
    localparam logic [22:0] Q900_MUL = 23'(((64'd1 << Q900_SH) + 64'd899) / 64'd900);

    // 400-year and 900-year cycles
    localparam int CYC_SH   = 49;
    localparam int GC_DIV   = 146097;
    localparam int GC_BIAS  = 2700;
    localparam logic [29:0] GC_OFS = 30'd394461900;
    localparam logic [31:0] GC_MUL = 32'(((64'd1 << CYC_SH) + 64'd146096) / 64'd146097);
    localparam int RC_DIV   = 328718;
    localparam int RC_BIAS  = 1200;
    localparam logic [29:0] RC_OFS = 30'd394461600;
    localparam logic [31:0] RC_MUL = 32'(((64'd1 << CYC_SH) + 64'd328717) / 64'd328718);

    // four-year cycle
    localparam int Y4_SH   = 41;
    localparam int Y4_DIV  = 1461;
    localparam logic [29:0] Y4_OFS = 30'd394470000;
    localparam logic [21:0] Y4_BIAS = 22'd270000;
    localparam logic [30:0] Y4_MUL = 31'(((64'd1 << Y4_SH) + 64'd1460) / 64'd1461);

    function automatic logic signed [9:0] month_ofs(input logic [3:0] m);
        logic signed [9:0] v;
        case (m)
            4'd3: v = -10'sd1;
            4'd4: v = 10'sd30;
            4'd5: v = 10'sd60;
            4'd6: v = 10'sd91;
            4'd7: v = 10'sd121;
            4'd8: v = 10'sd152;
            4'd9: v = 10'sd183;
            4'd10: v = 10'sd213;
            4'd11: v = 10'sd244;
            4'd12: v = 10'sd274;
            4'd13: v = 10'sd305;
            4'd14: v = 10'sd336;
            4'd15: v = 10'sd366;
            default: v = 10'sd0;
        endcase
        return v;
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] mo);
        logic [8:0] v;
        case (mo)
            4'd1: v = 9'd31;
            4'd2: v = 9'd61;
            4'd3: v = 9'd92;
            4'd4: v = 9'd122;
            4'd5: v = 9'd153;
            4'd6: v = 9'd184;
            4'd7: v = 9'd214;
            4'd8: v = 9'd245;
            4'd9: v = 9'd275;
            4'd10: v = 9'd306;
            4'd11: v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/calendar_date_converter_unit.sv =====
// Calendar date converter: eleven-stage pipeline through a day count.
// Depends on cdcu_pkg and calendar_date_converter_unit_macros.svh.
// One word accepted every cycle, busy stays low.
// Each result is shown for one cycle with o_valid; the receiver cannot stall.
// Synchronous active-low reset empties the pipeline and restores the year bounds.
`include "calendar_date_converter_unit_macros.svh"

module calendar_date_converter_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_kind,
    input  logic signed [20:0]     i_in_year,
    input  logic [3:0]             i_in_month,
    input  logic [4:0]             i_in_day,
    output logic                   o_valid,
    output logic signed [20:0]     o_out_year,
    output logic [3:0]             o_out_month,
    output logic [4:0]             o_out_day,
    output logic                   o_error_code,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [0:0]             i_cfg_index,
    input  logic signed [20:0]     i_cfg_data
);

    logic [10:1]        r_vld;
    cdcu_pkg::t_ctl     r_ctl [1:10];
    cdcu_pkg::t_ctl     n_ctl;
    cdcu_pkg::t_year    r_min_year;
    cdcu_pkg::t_year    r_max_year;
    logic               r_out_vld;

    logic signed [21:0] r_s1_ys,   n_s1_ys;
    logic [3:0]         r_s1_ms,   n_s1_ms;
    logic [4:0]         r_s1_day;

    logic signed [19:0] s2_q4;
    logic [19:0]        s2_u25;
    logic [21:0]        s2_u9a, s2_u9b;
    logic [40:0]        r_s2_p25,  n_s2_p25;
    logic [44:0]        r_s2_p9a,  n_s2_p9a;
    logic [44:0]        r_s2_p9b,  n_s2_p9b;
    logic signed [29:0] r_s2_y365, n_s2_y365;
    logic signed [20:0] r_s2_bp,   n_s2_bp;

    logic signed [15:0] s3_q100, s3_q400;
    logic signed [12:0] s3_r9a, s3_r9b;
    logic signed [30:0] r_s3_base, n_s3_base;
    logic signed [15:0] r_s3_corr, n_s3_corr;

    logic signed [30:0] r_s4_cnt,  n_s4_cnt;

    logic [29:0]        r_s5_u,    n_s5_u;
    logic [61:0]        r_s5_p,    n_s5_p;
    logic signed [30:0] r_s5_cnt;

    logic [12:0]        s6_c;
    logic [18:0]        s6_div;
    logic [13:0]        s6_bias;
    logic [18:0]        r_s6_rem,  n_s6_rem;
    logic signed [13:0] r_s6_cs,   n_s6_cs;
    logic signed [30:0] r_s6_cnt;

    logic [20:0]        s7_r4;
    logic [21:0]        s7_r9;
    logic [1:0]         s7_ag;
    logic [3:0]         s7_ar, s7_adj;
    logic signed [30:0] r_s7_e,    n_s7_e;

    logic [29:0]        r_s8_u,    n_s8_u;
    logic [60:0]        r_s8_p,    n_s8_p;

    logic [19:0]        s9_c;
    logic [10:0]        r_s9_rem,  n_s9_rem;
    logic signed [21:0] r_s9_yq,   n_s9_yq;

    logic [1:0]         s10_yr;
    logic [8:0]         r_s10_r2,  n_s10_r2;
    logic signed [22:0] r_s10_yb,  n_s10_yb;

    logic [3:0]         s11_mo;
    logic               s11_wrap;
    logic signed [20:0] r_out_year,  n_out_year;
    logic [3:0]         r_out_month, n_out_month;
    logic [4:0]         r_out_day,   n_out_day;
    logic               r_out_err;

    assign busy         = 1'b0;
    assign o_cfg_ready  = 1'b1;
    assign o_valid      = r_out_vld;
    assign o_out_year   = r_out_year;
    assign o_out_month  = r_out_month;
    assign o_out_day    = r_out_day;
    assign o_error_code = r_out_err;

    // stage 1: bounds check and March-based month shift
    always_comb begin
        n_ctl.kind = i_kind;
        n_ctl.err  = (i_in_year < r_min_year) || (i_in_year > r_max_year);
        n_s1_ys    = $signed({i_in_year[20], i_in_year})
                   - $signed({21'd0, (i_in_month < 4'd3)});
        n_s1_ms    = (i_in_month < 4'd3) ? i_in_month + 4'd12 : i_in_month;
    end

    // stage 2: year divisions by reciprocal, linear terms
    always_comb begin
        s2_q4     = r_s1_ys[21:2];
        s2_u25    = 20'(s2_q4) + cdcu_pkg::Q25_OFS;
        n_s2_p25  = s2_u25 * cdcu_pkg::Q25_MUL;
        s2_u9a    = 22'(r_s1_ys) + cdcu_pkg::Q900_OFS_A;
        s2_u9b    = 22'(r_s1_ys) + cdcu_pkg::Q900_OFS_B;
        n_s2_p9a  = s2_u9a * cdcu_pkg::Q900_MUL;
        n_s2_p9b  = s2_u9b * cdcu_pkg::Q900_MUL;
        n_s2_y365 = 30'(r_s1_ys) * 30'sd365;
        n_s2_bp   = 21'(s2_q4) + 21'(cdcu_pkg::month_ofs(r_s1_ms)) + 21'(r_s1_day);
    end

    // stage 3: leap corrections per source and target calendar
    always_comb begin
        s3_q100 = $signed(16'(r_s2_p25[40:cdcu_pkg::Q25_SH])
                - 16'(cdcu_pkg::Q25_BIAS));
        s3_q400 = s3_q100 >>> 2;
        s3_r9a  = $signed(r_s2_p9a[44:cdcu_pkg::Q900_SH] - 13'(cdcu_pkg::Q900_BIAS));
        s3_r9b  = $signed(r_s2_p9b[44:cdcu_pkg::Q900_SH] - 13'(cdcu_pkg::Q900_BIAS));
        n_s3_base = 31'(r_s2_y365) + 31'(r_s2_bp);
        case (r_ctl[2].kind)
            cdcu_pkg::KIND_G2J: n_s3_corr = s3_q400 - s3_q100 + 16'sd2;
            cdcu_pkg::KIND_J2G: n_s3_corr = -16'sd2;
            cdcu_pkg::KIND_G2R: n_s3_corr = s3_q400 - s3_q100;
            default:            n_s3_corr = 16'(s3_r9a) + 16'(s3_r9b) - s3_q100;
        endcase
    end

    // stage 4: day count from March 1 of year 0
    assign n_s4_cnt = r_s3_base + 31'(r_s3_corr);

    // stage 5: cycle quotient product
    always_comb begin
        if (r_ctl[4].kind == cdcu_pkg::KIND_G2R) begin
            n_s5_u = 30'(r_s4_cnt) + cdcu_pkg::RC_OFS;
            n_s5_p = n_s5_u * cdcu_pkg::RC_MUL;
        end else begin
            n_s5_u = 30'(r_s4_cnt) + cdcu_pkg::GC_OFS;
            n_s5_p = n_s5_u * cdcu_pkg::GC_MUL;
        end
    end

    // stage 6: cycle count and remainder
    always_comb begin
        if (r_ctl[5].kind == cdcu_pkg::KIND_G2R) begin
            s6_div  = 19'(cdcu_pkg::RC_DIV);
            s6_bias = 14'(cdcu_pkg::RC_BIAS);
        end else begin
            s6_div  = 19'(cdcu_pkg::GC_DIV);
            s6_bias = 14'(cdcu_pkg::GC_BIAS);
        end
        s6_c     = r_s5_p[61:cdcu_pkg::CYC_SH];
        n_s6_rem = 19'(r_s5_u - 30'(s6_c) * 30'(s6_div));
        n_s6_cs  = $signed(14'(s6_c) - s6_bias);
    end

    // stage 7: target calendar folded onto a four-year day count
    always_comb begin
        s7_r4 = {r_s6_rem, 2'b11};
        s7_r9 = 22'({r_s6_rem, 3'b000}) + 22'(r_s6_rem) + 22'd2;
        s7_ag = '0;
        s7_ar = '0;
        for (int k = 1; k <= 3; k++) begin
            if (s7_r4 >= 21'(cdcu_pkg::GC_DIV * k)) s7_ag = s7_ag + 2'd1;
        end
        for (int k = 1; k <= 8; k++) begin
            if (s7_r9 >= 22'(cdcu_pkg::RC_DIV * k)) s7_ar = s7_ar + 4'd1;
        end
        s7_adj = s7_ar - 4'((s7_ar >= 4'd6)) - 4'((s7_ar >= 4'd2));
        case (r_ctl[6].kind)
            cdcu_pkg::KIND_G2J: n_s7_e = r_s6_cnt;
            cdcu_pkg::KIND_G2R: n_s7_e = r_s6_cnt + 31'(r_s6_cs) * 31'sd7 + 31'(s7_adj);
            default:            n_s7_e = r_s6_cnt + 31'(r_s6_cs) * 31'sd3 + 31'(s7_ag);
        endcase
    end

    // stage 8: four-year quotient product
    always_comb begin
        n_s8_u = 30'(r_s7_e) + cdcu_pkg::Y4_OFS;
        n_s8_p = n_s8_u * cdcu_pkg::Y4_MUL;
    end

    // stage 9: four-year count and remainder
    always_comb begin
        s9_c     = r_s8_p[60:cdcu_pkg::Y4_SH];
        n_s9_rem = 11'(r_s8_u - 30'(s9_c) * 30'(cdcu_pkg::Y4_DIV));
        n_s9_yq  = $signed(22'(s9_c) - cdcu_pkg::Y4_BIAS);
    end

    // stage 10: year within the four-year cycle
    always_comb begin
        s10_yr   = 2'((r_s9_rem >= 11'd365)) + 2'((r_s9_rem >= 11'd730))
                 + 2'((r_s9_rem >= 11'd1095));
        n_s10_r2 = 9'(r_s9_rem - 11'(s10_yr) * 11'd365);
        n_s10_yb = 23'({r_s9_yq, 2'b00}) + 23'(s10_yr);
    end

    // stage 11: month and day, zero the date on error
    always_comb begin
        s11_mo = '0;
        for (int k = 1; k <= 11; k++) begin
            if (r_s10_r2 >= cdcu_pkg::month_start(4'(k))) s11_mo = s11_mo + 4'd1;
        end
        s11_wrap    = (s11_mo >= 4'd10);
        n_out_day   = 5'(r_s10_r2 - cdcu_pkg::month_start(s11_mo) + 9'd1);
        n_out_month = s11_wrap ? s11_mo - 4'd9 : s11_mo + 4'd3;
        n_out_year  = 21'(r_s10_yb + 23'(s11_wrap));
        if (r_ctl[10].err) begin
            n_out_day   = '0;
            n_out_month = '0;
            n_out_year  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_out_vld  <= 1'b0;
            r_min_year <= cdcu_pkg::MIN_YEAR_RST;
            r_max_year <= cdcu_pkg::MAX_YEAR_RST;
        end else begin
            r_vld     <= {r_vld[9:1], start & ~busy};
            r_out_vld <= r_vld[10];
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    cdcu_pkg::CFG_MIN_YEAR: r_min_year <= i_cfg_data;
                    cdcu_pkg::CFG_MAX_YEAR: r_max_year <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl[1] <= n_ctl;
        for (int i = 2; i <= 10; i++) begin
            r_ctl[i] <= r_ctl[i-1];
        end
        r_s1_ys     <= n_s1_ys;
        r_s1_ms     <= n_s1_ms;
        r_s1_day    <= i_in_day;
        r_s2_p25    <= n_s2_p25;
        r_s2_p9a    <= n_s2_p9a;
        r_s2_p9b    <= n_s2_p9b;
        r_s2_y365   <= n_s2_y365;
        r_s2_bp     <= n_s2_bp;
        r_s3_base   <= n_s3_base;
        r_s3_corr   <= n_s3_corr;
        r_s4_cnt    <= n_s4_cnt;
        r_s5_u      <= n_s5_u;
        r_s5_p      <= n_s5_p;
        r_s5_cnt    <= r_s4_cnt;
        r_s6_rem    <= n_s6_rem;
        r_s6_cs     <= n_s6_cs;
        r_s6_cnt    <= r_s5_cnt;
        r_s7_e      <= n_s7_e;
        r_s8_u      <= n_s8_u;
        r_s8_p      <= n_s8_p;
        r_s9_rem    <= n_s9_rem;
        r_s9_yq     <= n_s9_yq;
        r_s10_r2    <= n_s10_r2;
        r_s10_yb    <= n_s10_yb;
        r_out_year  <= n_out_year;
        r_out_month <= n_out_month;
        r_out_day   <= n_out_day;
        r_out_err   <= r_ctl[10].err;
    end

    `CDCU_CHECK(a_err_zero, o_valid && o_error_code,
        (o_out_year == 21'sd0) && (o_out_month == 4'd0) && (o_out_day == 5'd0),
        "error word carries a date")
    `CDCU_CHECK(a_month_range, o_valid && !o_error_code,
        (o_out_month >= 4'd1) && (o_out_month <= 4'd12), "month out of range")
    `CDCU_CHECK(a_latency, o_valid, $past(start && !busy, cdcu_pkg::LATENCY),
        "result without a matching start")
    `CDCU_CHECK(a_rem_cycle, r_vld[6],
        (r_ctl[6].kind == cdcu_pkg::KIND_G2R) ? (r_s6_rem < 19'(cdcu_pkg::RC_DIV))
            : (r_s6_rem < 19'(cdcu_pkg::GC_DIV)),
        "cycle remainder out of range")
    `CDCU_CHECK(a_rem_year, r_vld[9], r_s9_rem < 11'(cdcu_pkg::Y4_DIV),
        "four-year remainder out of range")
    `CDCU_CHECK_NEXT(a_cfg_min, i_cfg_valid && (i_cfg_index == cdcu_pkg::CFG_MIN_YEAR),
        r_min_year == $past(i_cfg_data), "lower bound not written")

endmodule
